FILE: hdl/vjr_pkg.sv
`timescale 1ns / 1ps

package vjr_pkg;

	// Sizing
	localparam int SPEAKERS    = 8;
	localparam int FIFO_DEPTH  = 16384;
	localparam int SPK_W       = (SPEAKERS > 1) ? $clog2(SPEAKERS) : 1;
	localparam int PTR_W       = $clog2(FIFO_DEPTH);
	localparam int FILL_W      = $clog2(FIFO_DEPTH + 1);
	localparam int STORE_AW    = SPK_W + PTR_W;
	localparam int STORE_DEPTH = 1 << STORE_AW;

	// Fixed-point constants
	localparam int GAIN_FLOOR = 32;
	localparam int GAIN_ONE   = 32768;
	localparam int SMOOTH_Q16 = 11796;
	localparam int MIX_Q16    = 47186;

	typedef enum logic [1:0] {
		ACT_PUSH  = 2'd0,
		ACT_GAIN  = 2'd1,
		ACT_MIX   = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	localparam logic [1:0] CFG_ENABLE   = 2'd0;
	localparam logic [1:0] CFG_STEP     = 2'd1;
	localparam logic [1:0] CFG_PREBUF   = 2'd2;
	localparam logic [1:0] CFG_MAXBUF   = 2'd3;

	// Per-speaker record held in the speaker memory
	typedef struct packed {
		logic [PTR_W-1:0]  rp;
		logic [FILL_W-1:0] fill;
		logic [15:0]       sg;
		logic [15:0]       gg;
		logic [15:0]       ph;
		logic signed [15:0] cur;
		logic signed [15:0] nxt;
		logic              primed;
	} spk_rec_t;

	localparam int REC_W = $bits(spk_rec_t);

	// Request to the voice arithmetic unit
	typedef struct packed {
		logic               start;
		logic signed [15:0] cur;
		logic signed [15:0] nxt;
		logic [15:0]        ph;
		logic [15:0]        gain;
	} voice_req_t;

endpackage

FILE: hdl/vjr_ram.sv
`timescale 1ns / 1ps

module vjr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// single write port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: hdl/vjr_voice.sv
`timescale 1ns / 1ps

module vjr_voice import vjr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  voice_req_t         req,
	output logic               done,
	output logic signed [16:0] value
);

	typedef enum logic [2:0] {
		V_IDLE,
		V_MUL,
		V_SUM,
		V_LO,
		V_HI,
		V_RND
	} vstate_t;

	vstate_t            state_q;
	logic signed [16:0] diff_q;
	logic signed [15:0] cur_q;
	logic [15:0]        ph_q;
	logic [15:0]        gain_q;
	logic signed [33:0] t_q;
	logic [30:0]        k_q;
	logic [32:0]        mag_q;
	logic               neg_q;
	logic [63:0]        p_q;

	logic signed [33:0] t_d;
	logic [31:0]        k_d;
	logic signed [33:0] interp_d;
	logic [33:0]        mag_d;
	logic [48:0]        lo_d;
	logic [47:0]        hi_d;
	logic [63:0]        rnd_d;
	logic [16:0]        r_d;

	// interpolation, gain scaling, split wide product, rounding
	always_comb begin
		t_d      = diff_q * $signed({1'b0, ph_q});
		k_d      = 32'(gain_q) * 32'(MIX_Q16);
		interp_d = t_q + $signed({{2{cur_q[15]}}, cur_q, 16'd0});
		mag_d    = interp_d[33] ? 34'(-interp_d) : interp_d;
		lo_d     = mag_q * k_q[15:0];
		hi_d     = mag_q * k_q[30:16];
		rnd_d    = p_q + (64'd1 << 46);
		r_d      = rnd_d[63:47];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= V_IDLE;
			done    <= 1'b0;
			value   <= '0;
			diff_q  <= '0;
			cur_q   <= '0;
			ph_q    <= '0;
			gain_q  <= '0;
			t_q     <= '0;
			k_q     <= '0;
			mag_q   <= '0;
			neg_q   <= 1'b0;
			p_q     <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				V_IDLE: begin
					if (req.start) begin
						diff_q  <= 17'(req.nxt) - 17'(req.cur);
						cur_q   <= req.cur;
						ph_q    <= req.ph;
						gain_q  <= req.gain;
						state_q <= V_MUL;
					end
				end
				V_MUL: begin
					t_q     <= t_d;
					k_q     <= k_d[30:0];
					state_q <= V_SUM;
				end
				V_SUM: begin
					neg_q   <= interp_d[33];
					mag_q   <= mag_d[32:0];
					state_q <= V_LO;
				end
				V_LO: begin
					p_q     <= 64'(lo_d);
					state_q <= V_HI;
				end
				V_HI: begin
					p_q     <= p_q + {hi_d, 16'd0};
					state_q <= V_RND;
				end
				V_RND: begin
					value   <= neg_q ? -$signed(r_d) : $signed(r_d);
					done    <= 1'b1;
					state_q <= V_IDLE;
				end
				default: state_q <= V_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	// a result follows a start from idle after the multiply, sum, low, high and round states
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == V_IDLE && req.start) |=> ##5 done)
		else $error("voice result latency broken");
	// no new request is taken while a product is in flight
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != V_IDLE) |=> !(done && state_q != V_IDLE))
		else $error("voice unit overlap");
	// result is a single pulse
	a_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("voice done held");
`endif

endmodule

FILE: hdl/voice_jitter_resample_mixer.sv
`timescale 1ns / 1ps
// Push and set gain read the speaker record and then write it back; clear all completes
// in idle, and a bypassed mix goes straight to the output register. Other mixes read each
// speaker's record, run the voice unit for each that plays, and pop while priming and advancing.
// Throughput: one item at a time; a finished frame waits in the output register
// while the next item is taken. Reset: asynchronous, clears registers to their
// reset values and all speaker valid bits; the sample memory is not cleared.
module voice_jitter_resample_mixer import vjr_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         action,
	input  logic [2:0]         slot,
	input  logic signed [15:0] sample,
	input  logic [15:0]        goal_in,
	input  logic signed [15:0] left_in,
	input  logic signed [15:0] right_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [15:0] left_out,
	output logic signed [15:0] right_out,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [18:0]        cfg_data
);

	localparam int CW = ((FILL_W > 15) ? FILL_W : 15) + 1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_PUSH,
		ST_GAIN,
		ST_MEVAL,
		ST_PRIME1W,
		ST_PRIME2W,
		ST_VOICE,
		ST_VWAIT,
		ST_ADV,
		ST_ADVW,
		ST_MWB,
		ST_MRD,
		ST_MDONE
	} state_t;

	state_t             state_q;
	logic               enable_q;
	logic [18:0]        step_q;
	logic [14:0]        prebuf_q;
	logic [14:0]        maxbuf_q;
	action_t            action_q;
	logic [SPK_W-1:0]   spk_q;
	logic signed [15:0] sample_q;
	logic [15:0]        tgain_q;
	logic signed [15:0] left_q;
	logic signed [15:0] right_q;
	logic [SPEAKERS-1:0] spk_vld_q;
	spk_rec_t           rec_q;
	logic [19:0]        phw_q;

	logic [REC_W-1:0]   rec_rdata;
	spk_rec_t           rec_rd;
	logic               rec_we;
	spk_rec_t           rec_wdata;
	logic [SPK_W-1:0]   rec_raddr;
	logic               st_we;
	logic [STORE_AW-1:0] st_waddr;
	logic [15:0]        st_rdata;
	logic               pop_en;
	logic               out_load;
	voice_req_t         vreq;
	logic               v_done;
	logic signed [16:0] v_value;

	spk_rec_t           push_rec;
	logic [PTR_W-1:0]   push_w;
	logic               push_ok;
	spk_rec_t           gain_rec;
	spk_rec_t           pop_rec;
	logic [CW-1:0]      limit_c;
	logic [CW-1:0]      need_c;
	logic               in_req;

	function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
			input logic [FILL_W-1:0] n);
		logic [FILL_W:0] s;
		s = (FILL_W+1)'(p) + (FILL_W+1)'(n);
		if (s >= (FILL_W+1)'(FIFO_DEPTH)) begin
			s = s - (FILL_W+1)'(FIFO_DEPTH);
		end
		return s[PTR_W-1:0];
	endfunction

	function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
			input logic signed [16:0] b);
		logic signed [17:0] s;
		s = 18'(a) + 18'(b);
		if (s > 18'sd32767) begin
			return 16'sh7fff;
		end else if (s < -18'sd32768) begin
			return 16'sh8000;
		end
		return s[15:0];
	endfunction

	// Memories: speaker records and sample FIFOs
	vjr_ram #(.WIDTH(REC_W), .DEPTH(SPEAKERS)) u_rec_ram (
		.clk   (clk),
		.we    (rec_we),
		.waddr (spk_q),
		.wdata (rec_wdata),
		.raddr (rec_raddr),
		.rdata (rec_rdata)
	);

	vjr_ram #(.WIDTH(16), .DEPTH(STORE_DEPTH)) u_store_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (sample_q),
		.raddr ({spk_q, rec_q.rp}),
		.rdata (st_rdata)
	);

	vjr_voice u_voice (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (vreq),
		.done   (v_done),
		.value  (v_value)
	);

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_req    = in_valid && in_ready;
	assign rec_raddr = (state_q == ST_IDLE) ? SPK_W'(slot) : spk_q;
	assign rec_rd    = spk_vld_q[spk_q] ? spk_rec_t'(rec_rdata) : '0;
	assign out_load  = (state_q == ST_MDONE) && (!out_valid || out_ready);

	// Fill limit and priming threshold
	always_comb begin
		limit_c = (CW'(maxbuf_q) < CW'(FIFO_DEPTH)) ? CW'(maxbuf_q) : CW'(FIFO_DEPTH);
		need_c  = (prebuf_q < 15'd2) ? CW'(2) : CW'(prebuf_q);
	end

	// Push: drop oldest when full, write at tail, trim to the limit
	always_comb begin
		push_rec = rec_q;
		push_ok  = (rec_q.gg > 16'(GAIN_FLOOR));
		if (CW'(push_rec.fill) >= CW'(FIFO_DEPTH)) begin
			push_rec.rp   = ptr_add(push_rec.rp, FILL_W'(1));
			push_rec.fill = push_rec.fill - FILL_W'(1);
		end
		push_w        = ptr_add(push_rec.rp, push_rec.fill);
		push_rec.fill = push_rec.fill + FILL_W'(1);
		if (CW'(push_rec.fill) > limit_c) begin
			push_rec.rp   = ptr_add(push_rec.rp, push_rec.fill - FILL_W'(limit_c));
			push_rec.fill = FILL_W'(limit_c);
		end
	end

	// Set gain: clamp, mute clears the FIFO, one smoothing step
	always_comb begin
		logic [15:0]        g;
		logic signed [16:0] d;
		logic [16:0]        mag;
		logic [32:0]        prod;
		logic [15:0]        stp;
		g        = (tgain_q > 16'(GAIN_ONE)) ? 16'(GAIN_ONE) : tgain_q;
		d        = $signed({1'b0, g}) - $signed({1'b0, rec_q.sg});
		mag      = d[16] ? 17'(-d) : d;
		prod     = 33'(mag) * 33'(SMOOTH_Q16) + 33'd32768;
		stp      = prod[31:16];
		gain_rec = rec_q;
		gain_rec.gg = g;
		if (g <= 16'(GAIN_FLOOR)) begin
			gain_rec.fill   = '0;
			gain_rec.primed = 1'b0;
		end
		gain_rec.sg = d[16] ? (rec_q.sg - stp) : (rec_q.sg + stp);
	end

	// Pop bookkeeping for the head read issued this cycle
	always_comb begin
		pop_rec      = rec_q;
		pop_rec.rp   = ptr_add(rec_q.rp, FILL_W'(1));
		pop_rec.fill = rec_q.fill - FILL_W'(1);
		pop_en = 1'b0;
		unique case (state_q)
			ST_MEVAL:  pop_en = (rec_q.sg > 16'(GAIN_FLOOR)) && !rec_q.primed &&
				(CW'(rec_q.fill) >= need_c);
			ST_PRIME1W: pop_en = 1'b1;
			ST_ADV:    pop_en = (phw_q[19:16] != 4'd0) && (rec_q.fill != '0);
			default:   pop_en = 1'b0;
		endcase
	end

	// Memory write controls
	always_comb begin
		rec_we    = 1'b0;
		rec_wdata = rec_q;
		st_we     = 1'b0;
		st_waddr  = {spk_q, push_w};
		unique case (state_q)
			ST_PUSH: begin
				rec_we    = push_ok;
				rec_wdata = push_rec;
				st_we     = push_ok;
			end
			ST_GAIN: begin
				rec_we    = 1'b1;
				rec_wdata = gain_rec;
			end
			ST_MWB:  rec_we = 1'b1;
			default: rec_we = 1'b0;
		endcase
	end

	always_comb begin
		vreq.start = (state_q == ST_VOICE);
		vreq.cur   = rec_q.cur;
		vreq.nxt   = rec_q.nxt;
		vreq.ph    = rec_q.ph;
		vreq.gain  = rec_q.sg;
	end

	// Sequencer, configuration and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			enable_q  <= 1'b1;
			step_q    <= 19'd65536;
			prebuf_q  <= 15'd2880;
			maxbuf_q  <= 15'd11520;
			action_q  <= ACT_PUSH;
			spk_q     <= '0;
			sample_q  <= '0;
			tgain_q   <= '0;
			left_q    <= '0;
			right_q   <= '0;
			spk_vld_q <= '0;
			rec_q     <= '0;
			phw_q     <= '0;
			out_valid <= 1'b0;
			left_out  <= '0;
			right_out <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_ENABLE: enable_q <= cfg_data[0];
					CFG_STEP:   step_q   <= cfg_data;
					CFG_PREBUF: prebuf_q <= cfg_data[14:0];
					CFG_MAXBUF: maxbuf_q <= cfg_data[14:0];
					default:    enable_q <= enable_q;
				endcase
			end
			if (out_valid && out_ready && !out_load) begin
				out_valid <= 1'b0;
			end
			if (rec_we) begin
				spk_vld_q[spk_q] <= 1'b1;
			end
			if (pop_en) begin
				rec_q.rp   <= pop_rec.rp;
				rec_q.fill <= pop_rec.fill;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_req) begin
						action_q <= action_t'(action);
						// a mix walks the speakers from the first one
						spk_q    <= (action_t'(action) == ACT_MIX) ? '0 : SPK_W'(slot);
						sample_q <= sample;
						tgain_q  <= goal_in;
						left_q   <= left_in;
						right_q  <= right_in;
						unique case (action_t'(action))
							ACT_PUSH, ACT_GAIN: begin
								state_q <= (32'(slot) < SPEAKERS) ? ST_RD : ST_IDLE;
							end
							ACT_MIX: begin
								state_q <= (enable_q && step_q != '0) ? ST_MRD : ST_MDONE;
							end
							ACT_CLEAR: spk_vld_q <= '0;
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_MRD: state_q <= ST_RD;
				ST_RD: begin
					rec_q <= rec_rd;
					unique case (action_q)
						ACT_PUSH: state_q <= ST_PUSH;
						ACT_GAIN: state_q <= ST_GAIN;
						default:  state_q <= ST_MEVAL;
					endcase
				end
				ST_PUSH: state_q <= ST_IDLE;
				ST_GAIN: state_q <= ST_IDLE;
				ST_MEVAL: begin
					if (rec_q.sg <= 16'(GAIN_FLOOR)) begin
						state_q <= ST_MWB;
					end else if (rec_q.primed) begin
						state_q <= ST_VOICE;
					end else if (CW'(rec_q.fill) < need_c) begin
						state_q <= ST_MWB;
					end else begin
						state_q <= ST_PRIME1W;
					end
				end
				ST_PRIME1W: begin
					rec_q.cur <= $signed(st_rdata);
					state_q   <= ST_PRIME2W;
				end
				ST_PRIME2W: begin
					rec_q.nxt    <= $signed(st_rdata);
					rec_q.ph     <= '0;
					rec_q.primed <= 1'b1;
					state_q      <= ST_VOICE;
				end
				ST_VOICE: state_q <= ST_VWAIT;
				ST_VWAIT: begin
					if (v_done) begin
						left_q  <= sat_add(left_q, v_value);
						right_q <= sat_add(right_q, v_value);
						phw_q   <= 20'(rec_q.ph) + 20'(step_q);
						state_q <= ST_ADV;
					end
				end
				ST_ADV: begin
					if (phw_q[19:16] != 4'd0) begin
						phw_q[19:16] <= phw_q[19:16] - 4'd1;
						rec_q.cur    <= rec_q.nxt;
						if (rec_q.fill == '0) begin
							rec_q.primed <= 1'b0;
							rec_q.ph     <= phw_q[15:0];
							state_q      <= ST_MWB;
						end else begin
							state_q <= ST_ADVW;
						end
					end else begin
						rec_q.ph <= phw_q[15:0];
						state_q  <= ST_MWB;
					end
				end
				ST_ADVW: begin
					rec_q.nxt <= $signed(st_rdata);
					state_q   <= ST_ADV;
				end
				ST_MWB: begin
					if (32'(spk_q) == SPEAKERS - 1) begin
						state_q <= ST_MDONE;
					end else begin
						spk_q   <= spk_q + SPK_W'(1);
						state_q <= ST_MRD;
					end
				end
				ST_MDONE: begin
					if (out_load) begin
						out_valid <= 1'b1;
						left_out  <= left_q;
						right_out <= right_q;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef ASSERT_OFF
	// a waiting frame is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid || out_ready))
		else $error("output frame overwritten");
	// a sample is never popped from an empty FIFO
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop_en |-> (rec_q.fill != '0))
		else $error("pop from empty FIFO");
	// a finished mix presents its frame on the next cycle when the output is free
	a_mix_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MDONE && !out_valid) |=> out_valid)
		else $error("mix frame not delivered");
	// records are written back only by the push, gain and mix write-back steps
	a_rec_write: assert property (@(posedge clk) disable iff (!arst_n)
		rec_we |-> (state_q == ST_PUSH || state_q == ST_GAIN || state_q == ST_MWB))
		else $error("stray speaker record write");
`endif

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
	import vjr_pkg::*;

	localparam int WATCH_LIMIT = 20000;
	localparam int SETTLE      = 400;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_ready;
	logic [1:0]         action = ACT_PUSH;
	logic [2:0]         slot = 0;
	logic signed [15:0] sample = 0;
	logic [15:0]        goal_in = 0;
	logic signed [15:0] left_in = 0;
	logic signed [15:0] right_in = 0;
	logic               out_valid;
	logic               out_ready = 0;
	logic signed [15:0] left_out;
	logic signed [15:0] right_out;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic [1:0]         cfg_index = CFG_ENABLE;
	logic [18:0]        cfg_data = 0;

	voice_jitter_resample_mixer dut (.*);

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	// Expected stereo frames, oldest first
	typedef struct {
		logic signed [15:0] l;
		logic signed [15:0] r;
	} frame_t;
	frame_t frames_due[$];

	int  mismatches = 0;
	bit  calm = 0;
	int  idle_cycles = 0;

	// Mixer shadow: registers and per-speaker playback state
	bit                 m_en;
	int unsigned        m_step, m_prebuf, m_maxbuf;
	logic signed [15:0] jbuf [SPEAKERS][FIFO_DEPTH];
	int unsigned        rd_ptr [SPEAKERS];
	int unsigned        fill [SPEAKERS];
	int                 sm_gain [SPEAKERS];
	int                 goal [SPEAKERS];
	int unsigned        phase [SPEAKERS];
	int                 cur_s [SPEAKERS];
	int                 nxt_s [SPEAKERS];
	bit                 live [SPEAKERS];

	function automatic void wipe_speakers();
		for (int s = 0; s < SPEAKERS; s++) begin
			rd_ptr[s] = 0; fill[s] = 0; sm_gain[s] = 0; goal[s] = 0;
			phase[s] = 0; cur_s[s] = 0; nxt_s[s] = 0; live[s] = 0;
		end
	endfunction

	function automatic void discard(int s, int unsigned n);
		if (n > fill[s]) n = fill[s];
		rd_ptr[s] = (rd_ptr[s] + n) % FIFO_DEPTH;
		fill[s] -= n;
	endfunction

	function automatic int take(int s);
		int v;
		v = jbuf[s][rd_ptr[s]];
		discard(s, 1);
		return v;
	endfunction

	function automatic void enqueue(int s, logic signed [15:0] v);
		int unsigned lim;
		lim = (m_maxbuf < FIFO_DEPTH) ? m_maxbuf : FIFO_DEPTH;
		if (goal[s] <= GAIN_FLOOR) return;
		if (fill[s] >= FIFO_DEPTH) discard(s, 1);
		jbuf[s][(rd_ptr[s] + fill[s]) % FIFO_DEPTH] = v;
		fill[s]++;
		if (fill[s] > lim) discard(s, fill[s] - lim);
	endfunction

	function automatic void retarget(int s, int unsigned g);
		int d, stp;
		if (g > GAIN_ONE) g = GAIN_ONE;
		goal[s] = g;
		if (goal[s] <= GAIN_FLOOR) begin
			fill[s] = 0;
			live[s] = 0;
		end
		d = goal[s] - sm_gain[s];
		stp = ((d < 0 ? -d : d) * SMOOTH_Q16 + 32768) >>> 16;
		sm_gain[s] += (d < 0) ? -stp : stp;
	endfunction

	function automatic bit ready_to_play(int s);
		int unsigned need;
		need = (m_prebuf < 2) ? 2 : m_prebuf;
		if (live[s]) return 1;
		if (fill[s] < need) return 0;
		cur_s[s] = take(s);
		nxt_s[s] = take(s);
		phase[s] = 0;
		live[s] = 1;
		return 1;
	endfunction

	function automatic int voice_level(int s);
		longint interp, prod, mag;
		int r;
		interp = longint'(cur_s[s]) * 65536 + longint'(nxt_s[s] - cur_s[s]) * phase[s];
		prod = interp * sm_gain[s] * MIX_Q16;
		mag = (prod < 0) ? -prod : prod;
		r = int'((mag + (64'sd1 <<< 46)) >>> 47);
		return (prod < 0) ? -r : r;
	endfunction

	function automatic void step_phase(int s);
		int unsigned p;
		p = phase[s] + m_step;
		while (p >= 65536) begin
			p -= 65536;
			cur_s[s] = nxt_s[s];
			if (fill[s] == 0) begin
				live[s] = 0;
				break;
			end
			nxt_s[s] = take(s);
		end
		phase[s] = p & 16'hFFFF;
	endfunction

	function automatic int clip16(int v);
		return (v > 32767) ? 32767 : ((v < -32768) ? -32768 : v);
	endfunction

	function automatic frame_t mix_frame(logic signed [15:0] li, logic signed [15:0] ri);
		frame_t f;
		int l, r, v;
		l = li;
		r = ri;
		if (m_en && m_step != 0) begin
			for (int s = 0; s < SPEAKERS; s++) begin
				if (sm_gain[s] <= GAIN_FLOOR || !ready_to_play(s)) continue;
				v = voice_level(s);
				l = clip16(l + v);
				r = clip16(r + v);
				step_phase(s);
			end
		end
		f.l = 16'(l);
		f.r = 16'(r);
		return f;
	endfunction

	// Sender gap between requests
	task automatic sender_gap();
		if (!calm && $urandom_range(99) < 20) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Issue one request; chk marks a row with a typed expectation
	task automatic send(action_t a, int s, int smp, int g, int li, int ri,
			bit chk = 0, int el = 0, int er = 0);
		frame_t f;
		action <= a; slot <= 3'(s); sample <= 16'(smp); goal_in <= 16'(g);
		left_in <= 16'(li); right_in <= 16'(ri);
		in_valid <= 1;
		do @(posedge clk); while (!in_ready);
		case (a)
			ACT_PUSH:  enqueue(s, 16'(smp));
			ACT_GAIN:  retarget(s, g & 16'hFFFF);
			ACT_CLEAR: wipe_speakers();
			default: begin
				f = mix_frame(16'(li), 16'(ri));
				if (chk) begin
					f.l = 16'(el);
					f.r = 16'(er);
				end
				frames_due.push_back(f);
			end
		endcase
		sender_gap();
	endtask

	task automatic write_reg(logic [1:0] idx, int unsigned val);
		cfg_index <= idx;
		cfg_data <= 19'(val);
		cfg_valid <= 1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		case (idx)
			CFG_ENABLE: m_en = val[0];
			CFG_STEP:   m_step = val & 19'h7FFFF;
			CFG_PREBUF: m_prebuf = val & 15'h7FFF;
			default:    m_maxbuf = val & 15'h7FFF;
		endcase
	endtask

	// Block goes quiet before registers change
	task automatic drain();
		in_valid <= 0;
		while (frames_due.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic setup(bit en, int unsigned st, int unsigned pb, int unsigned mb);
		drain();
		write_reg(CFG_ENABLE, en);
		write_reg(CFG_STEP, st);
		write_reg(CFG_PREBUF, pb);
		write_reg(CFG_MAXBUF, mb);
	endtask

	task automatic random_item();
		int r, g, s;
		r = $urandom_range(99);
		s = $urandom_range(0, 7);
		if (r < 12) begin
			g = $urandom_range(99);
			if (g < 70) g = $urandom_range(2000, 32768);
			else if (g < 85) g = $urandom_range(0, 32);
			else g = $urandom_range(32769, 65535);
			send(ACT_GAIN, s, $urandom, g, $urandom, $urandom);
		end else if (r < 55) begin
			send(ACT_PUSH, s, $urandom, $urandom, $urandom, $urandom);
		end else if (r < 93) begin
			if ($urandom_range(9) == 0)
				send(ACT_MIX, s, $urandom, $urandom, 32767, -32768);
			else
				send(ACT_MIX, s, $urandom, $urandom, $urandom, $urandom);
		end else if (r < 96) begin
			send(ACT_CLEAR, s, $urandom, $urandom, $urandom, $urandom);
		end else begin
			send(action_t'($urandom_range(0, 3)), s, $urandom, $urandom,
				$urandom, $urandom);
		end
	endtask

	task automatic random_phase(int n);
		// bring half the speakers up to audible gain first
		for (int s = 0; s < 4; s++)
			repeat (3) send(ACT_GAIN, s, 0, 32768, 0, 0);
		repeat (n) random_item();
	endtask

	// Directed rows
	typedef struct {
		action_t a;
		int      s, smp, g, li, ri;
		bit      chk;
		int      el, er;
	} row_t;

	row_t rows[] = '{
		'{ACT_MIX,   0, 0,      0,      32767,  -32768, 1, 32767,  -32768},
		'{ACT_PUSH,  0, 5,      0,      0,      0,      0, 0,      0},
		'{ACT_MIX,   0, 0,      0,      -32768, 32767,  1, -32768, 32767},
		'{ACT_GAIN,  0, 0,      65535,  0,      0,      0, 0,      0},
		'{ACT_GAIN,  7, 0,      32768,  0,      0,      0, 0,      0},
		'{ACT_GAIN,  7, 0,      32768,  0,      0,      0, 0,      0},
		'{ACT_PUSH,  7, -32768, 0,      0,      0,      0, 0,      0},
		'{ACT_PUSH,  7, 32767,  0,      0,      0,      0, 0,      0},
		'{ACT_PUSH,  7, 0,      0,      0,      0,      0, 0,      0},
		'{ACT_PUSH,  0, 1234,   0,      0,      0,      0, 0,      0},
		'{ACT_MIX,   0, 0,      0,      32767,  32767,  0, 0,      0},
		'{ACT_MIX,   0, 0,      0,      -32768, -32768, 0, 0,      0},
		'{ACT_MIX,   0, 0,      0,      0,      0,      0, 0,      0},
		'{ACT_MIX,   0, 0,      0,      100,    -100,   0, 0,      0},
		'{ACT_GAIN,  7, 0,      32,     0,      0,      0, 0,      0},
		'{ACT_PUSH,  7, 77,     0,      0,      0,      0, 0,      0},
		'{ACT_MIX,   0, 0,      0,      1,      -1,     0, 0,      0},
		'{ACT_CLEAR, 0, 0,      0,      0,      0,      0, 0,      0},
		'{ACT_MIX,   0, 0,      0,      0,      0,      1, 0,      0}
	};

	// Result checker
	always @(posedge clk) begin
		frame_t f;
		if (out_valid && out_ready) begin
			if (frames_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected frame L=%0d R=%0d", left_out, right_out);
			end else begin
				f = frames_due[0];
				frames_due.delete(0);
				if (f.l !== left_out || f.r !== right_out) begin
					mismatches++;
					if (mismatches <= 10)
						$display("frame mismatch: exp L=%0d R=%0d got L=%0d R=%0d",
							f.l, f.r, left_out, right_out);
				end
			end
		end
	end

	// Receiver stalls
	always @(posedge clk)
		out_ready <= calm || ($urandom_range(99) >= 20);

	// Watchdog on lack of progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) ||
					(cfg_valid && cfg_ready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles == WATCH_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	initial begin
		m_en = 1; m_step = 65536; m_prebuf = 2880; m_maxbuf = 11520;
		wipe_speakers();
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// reset defaults: no speaker is audible yet
		for (int i = 0; i < 3; i++)
			send(rows[i].a, rows[i].s, rows[i].smp, rows[i].g, rows[i].li,
				rows[i].ri, rows[i].chk, rows[i].el, rows[i].er);
		setup(1, 65536, 2, 8);
		foreach (rows[i])
			send(rows[i].a, rows[i].s, rows[i].smp, rows[i].g, rows[i].li,
				rows[i].ri, rows[i].chk, rows[i].el, rows[i].er);

		setup(1, 65536, 2, 8);       random_phase(230);
		setup(1, 32768, 4, 64);      random_phase(230);
		setup(1, 524287, 3, 40);     random_phase(230);
		setup(1, 0, 4, 64);          random_phase(120);
		setup(0, 65536, 4, 64);      random_phase(120);
		calm = 1;
		setup(1, 100000, 0, 2);      random_phase(230);
		calm = 0;
		setup(1, 70000, 16384, 11520); random_phase(120);
		setup(1, 1, 2, 16384);       random_phase(200);
		setup(1, 98304, 1, 3);       random_phase(230);

		// overfill one FIFO past its limit, then play it out a little
		setup(1, 65536, 8, 24);
		calm = 1;
		send(ACT_CLEAR, 0, 0, 0, 0, 0);
		repeat (3) send(ACT_GAIN, 2, 0, 32768, 0, 0);
		for (int i = 0; i < 40; i++)
			send(ACT_PUSH, 2, $urandom, 0, 0, 0);
		calm = 0;
		repeat (6) send(ACT_MIX, 0, 0, 0, $urandom, $urandom);

		drain();
		if (mismatches == 0 && frames_due.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
